[src/esc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Email syntax checker package
// Character codes and the byte class record shared by the checker modules.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam logic [7:0] CHAR_AT     = 8'd64;
   localparam logic [7:0] CHAR_DOT    = 8'd46;
   localparam logic [7:0] CHAR_UNDER  = 8'd95;
   localparam logic [7:0] CHAR_DASH   = 8'd45;
   localparam logic [7:0] LETTER_LOW  = 8'd65;
   localparam logic [7:0] LETTER_HIGH = 8'd122;
   localparam logic [7:0] GAP_LOW     = 8'd91;
   localparam logic [7:0] GAP_HIGH    = 8'd96;
   localparam logic [7:0] DIGIT_LOW   = 8'd48;
   localparam logic [7:0] DIGIT_HIGH  = 8'd57;
   localparam logic [1:0] TAIL_MIN    = 2'd2;

   typedef struct packed {
      logic is_letter;
      logic is_digit;
      logic is_at;
      logic is_dot;
      logic is_under;
      logic is_dash;
   } char_class_type;

endpackage
`default_nettype wire

[src/email_syntax_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Email syntax checker
// Takes an address one byte per item; the end-marker item yields one result.
// The result is registered: it is valid in the cycle after its end marker is accepted.
// Throughput: one item per cycle; a waiting result holds up only a further
// item, and the result register frees in the same cycle it is taken.
// Reset (synchronous, active high) restores the string flags and clears rsp_valid.
// ----------------------------------------------------------------------------
module email_syntax_checker
   import esc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_char_code,
   input  wire logic       req_end_marker,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_address_valid
);

   char_class_type cls;

   logic       at_seen_ff,   at_seen_in;
   logic       failed_ff,    failed_in;
   logic       started_ff,   started_in;
   logic       prev_sep_ff,  prev_sep_in;
   logic       prev_aln_ff,  prev_aln_in;
   logic       dot_seen_ff,  dot_seen_in;
   logic [1:0] tail_len_ff,  tail_len_in;
   logic       tail_let_ff,  tail_let_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_data_ff,  rsp_data_in;

   logic accept;
   logic alnum;
   logic local_sep;
   logic dom_sep;
   logic ok;

   esc_char_class u_char_class (
      .char_code  (req_char_code),
      .char_class (cls)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign alnum     = cls.is_letter || cls.is_digit;
   assign local_sep = cls.is_dot || cls.is_under;
   assign dom_sep   = cls.is_dot || cls.is_dash;
   assign ok        = at_seen_ff && !failed_ff && started_ff && dot_seen_ff &&
                      (tail_len_ff >= TAIL_MIN) && tail_let_ff;

   always_comb begin
      at_seen_in   = at_seen_ff;
      failed_in    = failed_ff;
      started_in   = started_ff;
      prev_sep_in  = prev_sep_ff;
      prev_aln_in  = prev_aln_ff;
      dot_seen_in  = dot_seen_ff;
      tail_len_in  = tail_len_ff;
      tail_let_in  = tail_let_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         if (req_end_marker) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ok;
            at_seen_in   = 1'b0;
            failed_in    = 1'b0;
            started_in   = 1'b0;
            prev_sep_in  = 1'b0;
            prev_aln_in  = 1'b0;
            dot_seen_in  = 1'b0;
            tail_len_in  = 2'd0;
            tail_let_in  = 1'b1;
         end else if (cls.is_at) begin
            if (at_seen_ff || !started_ff || !prev_aln_ff) begin
               failed_in = 1'b1;
            end
            at_seen_in  = 1'b1;
            started_in  = 1'b0;
            prev_sep_in = 1'b0;
            prev_aln_in = 1'b0;
         end else if (at_seen_ff) begin
            if ((!alnum && !dom_sep) || (!started_ff && !cls.is_letter) ||
                (dom_sep && prev_sep_ff)) begin
               failed_in = 1'b1;
            end
            started_in  = 1'b1;
            prev_sep_in = dom_sep;
            prev_aln_in = alnum;
            if (cls.is_dot) begin
               dot_seen_in = 1'b1;
               tail_len_in = 2'd0;
               tail_let_in = 1'b1;
            end else begin
               if (tail_len_ff < TAIL_MIN) begin
                  tail_len_in = tail_len_ff + 2'd1;
               end
               if (!cls.is_letter) begin
                  tail_let_in = 1'b0;
               end
            end
         end else begin
            if ((!alnum && !local_sep) || (!started_ff && !alnum) ||
                (local_sep && prev_sep_ff)) begin
               failed_in = 1'b1;
            end
            started_in  = 1'b1;
            prev_sep_in = local_sep;
            prev_aln_in = alnum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_seen_ff   <= 1'b0;
         failed_ff    <= 1'b0;
         started_ff   <= 1'b0;
         prev_sep_ff  <= 1'b0;
         prev_aln_ff  <= 1'b0;
         dot_seen_ff  <= 1'b0;
         tail_len_ff  <= 2'd0;
         tail_let_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         at_seen_ff   <= at_seen_in;
         failed_ff    <= failed_in;
         started_ff   <= started_in;
         prev_sep_ff  <= prev_sep_in;
         prev_aln_ff  <= prev_aln_in;
         dot_seen_ff  <= dot_seen_in;
         tail_len_ff  <= tail_len_in;
         tail_let_ff  <= tail_let_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_address_valid = rsp_data_ff;

endmodule
`default_nettype wire

[src/esc_char_class.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Email syntax checker byte classifier
// Sorts one byte into letter, digit and the punctuation the rules care about.
// ----------------------------------------------------------------------------
module esc_char_class
   import esc_pkg::*;
(
   input  wire logic [7:0]     char_code,
   output char_class_type      char_class
);

   always_comb begin
      char_class.is_letter = (char_code >= LETTER_LOW) && (char_code <= LETTER_HIGH) &&
                             !((char_code >= GAP_LOW) && (char_code <= GAP_HIGH));
      char_class.is_digit  = (char_code >= DIGIT_LOW) && (char_code <= DIGIT_HIGH);
      char_class.is_at     = (char_code == CHAR_AT);
      char_class.is_dot    = (char_code == CHAR_DOT);
      char_class.is_under  = (char_code == CHAR_UNDER);
      char_class.is_dash   = (char_code == CHAR_DASH);
   end

endmodule
`default_nettype wire
